FILE: rtl/rbia_pkg.sv
// ----------------------------------------------------------------------------
// rbia_pkg
// Shared types and constants for the indexed ring buffer: field widths,
// request and status codes, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rbia_pkg;

    localparam int DEPTH      = 256;
    localparam int ELEM_WIDTH = 8;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int REQ_W  = 3;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 9;
    localparam int DATA_W = 8;
    localparam int FILL_W = 9;
    localparam int CAP_W  = 9;

    localparam int GRP  = 16;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_GET    = 3'd2,
        REQ_SET    = 3'd3,
        REQ_REMOVE = 3'd4,
        REQ_CLEAR  = 3'd5
    } rbia_req_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } rbia_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SHIFT
    } rbia_state_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  run_length;
        logic [DATA_W-1:0] wr_data;
    } rbia_req_t;

    typedef struct packed {
        rbia_status_t      status;
        logic [DATA_W-1:0] rd_data;
        logic [FILL_W-1:0] fill_level;
    } rbia_rsp_t;

    typedef struct packed {
        logic                  shift;
        logic [IDX_W-1:0]      base;
        logic                  wr;
        logic [IDX_W-1:0]      waddr;
        logic [ELEM_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } rbia_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/rbia_cell.sv
// ----------------------------------------------------------------------------
// rbia_cell
// One element of the queue, kept in logical order. Takes its upper
// neighbour's value on a shift at or above the base, or the broadcast write
// data when addressed; drives its value onto the read tree when addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module rbia_cell
    import rbia_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [IDX_W-1:0]      cell_idx,
    input  wire rbia_cell_ctrl_t       ctrl,
    input  wire logic [ELEM_WIDTH-1:0] nbr_value,
    output logic      [ELEM_WIDTH-1:0] value,
    output logic      [ELEM_WIDTH-1:0] leaf
);

    logic [ELEM_WIDTH-1:0] value_reg;
    logic [ELEM_WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift && (cell_idx >= ctrl.base))
        begin
            value_next = nbr_value;
        end
        else if (ctrl.wr && (cell_idx == ctrl.waddr))
        begin
            value_next = ctrl.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign leaf  = (cell_idx == ctrl.raddr) ? value_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/rbia_rdtree.sv
// ----------------------------------------------------------------------------
// rbia_rdtree
// Two-level OR tree that collects the one addressed cell value. Group
// results are registered; the final OR over the groups is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module rbia_rdtree
    import rbia_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  load,
    input  wire logic [ELEM_WIDTH-1:0] leaf [DEPTH],
    output logic      [ELEM_WIDTH-1:0] result
);

    logic [ELEM_WIDTH-1:0] part     [NGRP][GRP];
    logic [ELEM_WIDTH-1:0] grp_next [NGRP];
    logic [ELEM_WIDTH-1:0] grp_reg  [NGRP];

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        for (genvar j = 0; j < GRP; j++)
        begin : g_leaf
            if ((g * GRP + j) < DEPTH)
            begin : g_used
                assign part[g][j] = leaf[g * GRP + j];
            end
            else
            begin : g_pad
                assign part[g][j] = '0;
            end
        end

        always_comb
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                grp_next[g] = grp_next[g] | part[g][j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            result = result | grp_reg[g];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ring_buffer_with_indexed_access.sv
// ----------------------------------------------------------------------------
// ring_buffer_with_indexed_access
// Queue of fixed-width elements with push, pop, indexed get and set, run
// removal and clear. Elements sit in a row of cells in logical order.
// ----------------------------------------------------------------------------
//  channel   handshake                          payload
//  request   start, busy                        req  (rbia_req_t)
//  result    done (one-cycle strobe)            rsp  (rbia_rsp_t)
//  config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//
//  Push, pop, set, clear, remove at the tail and refused beats complete in
//  the execute state. Get adds a read state for the registered group stage
//  of the read tree. Remove at the front or middle adds a shift state, the
//  cell row shifting one place per cycle until run_length places are gone.
//  Reset empties the queue and sets capacity to 256; no clearing pass.
//  Results cannot be held off; done marks each for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_with_indexed_access
    import rbia_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire rbia_req_t   req,
    output logic             done,
    output rbia_rsp_t        rsp
);

    rbia_state_t      state_reg;
    rbia_state_t      state_next;
    rbia_req_t        req_reg;
    rbia_req_t        req_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic [LEN_W-1:0] shift_cnt_reg;
    logic [LEN_W-1:0] shift_cnt_next;
    logic             done_reg;
    logic             done_next;
    rbia_rsp_t        rsp_reg;
    rbia_rsp_t        rsp_next;

    rbia_cell_ctrl_t       ctrl;
    logic                  tree_load;
    logic [ELEM_WIDTH-1:0] tree_data;
    logic [ELEM_WIDTH-1:0] cell_value [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_leaf  [DEPTH];

    logic             accept;
    logic             cfg_we;
    logic [CNT_W-1:0] cap_eff;
    logic [31:0]      pos_w;
    logic [31:0]      len_w;
    logic [31:0]      cnt_w;
    logic [31:0]      end_w;
    logic             is_full;
    logic             is_empty;
    logic             out_range;
    logic             rm_bad;
    logic             rm_tail;
    logic             rm_zero;
    logic             get_ok;
    logic             shift_go;

    assign accept = start && !busy;
    assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(cap_reg);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(cap_reg) > DEPTH)
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign pos_w     = 32'(req_reg.position);
    assign len_w     = 32'(req_reg.run_length);
    assign cnt_w     = 32'(count_reg);
    assign end_w     = pos_w + len_w;
    assign is_full   = cnt_w >= 32'(cap_eff);
    assign is_empty  = (count_reg == '0);
    assign out_range = pos_w >= cnt_w;
    assign rm_bad    = end_w > cnt_w;
    assign rm_tail   = end_w == cnt_w;
    assign rm_zero   = (req_reg.run_length == '0);
    assign get_ok    = (req_reg.req_type == REQ_GET) && !out_range;
    assign shift_go  = (req_reg.req_type == REQ_REMOVE) && !rm_bad && !rm_zero
                       && !rm_tail;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (get_ok)
                begin
                    state_next = S_READ;
                end
                else if (shift_go)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_SHIFT:
            begin
                if (shift_cnt_reg == LEN_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath control and result
    always_comb
    begin
        req_next       = req_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        shift_cnt_next = shift_cnt_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        tree_load      = 1'b0;
        ctrl.shift     = 1'b0;
        ctrl.base      = IDX_W'(req_reg.position);
        ctrl.wr        = 1'b0;
        ctrl.waddr     = IDX_W'(req_reg.position);
        ctrl.wdata     = ELEM_WIDTH'(req_reg.wr_data);
        ctrl.raddr     = IDX_W'(req_reg.position);

        if (accept)
        begin
            req_next = req;
        end
        if (cfg_we)
        begin
            cap_next   = pwdata[CAP_W-1:0];
            count_next = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                tree_load           = 1'b1;
                rsp_next.status     = ST_OK;
                rsp_next.rd_data    = '0;
                case (req_reg.req_type)
                    REQ_PUSH:
                    begin
                        if (is_full)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            ctrl.wr    = 1'b1;
                            ctrl.waddr = IDX_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    REQ_POP:
                    begin
                        if (is_empty)
                        begin
                            rsp_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            rsp_next.rd_data = DATA_W'(cell_value[0]);
                            ctrl.shift       = 1'b1;
                            ctrl.base        = '0;
                            count_next       = count_reg - CNT_W'(1);
                        end
                    end
                    REQ_GET:
                    begin
                        if (out_range)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                    end
                    REQ_SET:
                    begin
                        if (out_range)
                        begin
                            rsp_next.status = ST_RANGE;
                        end
                        else
                        begin
                            ctrl.wr = 1'b1;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (rm_bad)
                        begin
                            rsp_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            count_next     = count_reg - CNT_W'(req_reg.run_length);
                            shift_cnt_next = req_reg.run_length;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        rsp_next.status = ST_RANGE;
                    end
                endcase
                rsp_next.fill_level = FILL_W'(count_next);
                done_next           = !get_ok && !shift_go;
            end
            S_READ:
            begin
                rsp_next.status     = ST_OK;
                rsp_next.rd_data    = DATA_W'(tree_data);
                rsp_next.fill_level = FILL_W'(count_reg);
                done_next           = 1'b1;
            end
            S_SHIFT:
            begin
                ctrl.shift     = 1'b1;
                shift_cnt_next = shift_cnt_reg - LEN_W'(1);
                if (shift_cnt_reg == LEN_W'(1))
                begin
                    rsp_next.status     = ST_OK;
                    rsp_next.rd_data    = '0;
                    rsp_next.fill_level = FILL_W'(count_reg);
                    done_next           = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            shift_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            shift_cnt_reg <= shift_cnt_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] nbr;

        if (k == DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_value[k + 1];
        end

        rbia_cell u_cell (
            .clk       (clk),
            .cell_idx  (IDX_W'(k)),
            .ctrl      (ctrl),
            .nbr_value (nbr),
            .value     (cell_value[k]),
            .leaf      (cell_leaf[k])
        );
    end

    rbia_rdtree u_rdtree (
        .clk    (clk),
        .load   (tree_load),
        .leaf   (cell_leaf),
        .result (tree_data)
    );

endmodule

`default_nettype wire

FILE: dv/rbia_reply_checker.sv
// ----------------------------------------------------------------------------
// rbia_reply_checker
// Watches the request, reply and register channels of the indexed ring
// buffer. Keeps its own copy of the queue state, works out the reply owed
// for every accepted request beat and compares each reply beat against the
// oldest reply owed, field by field.
// ----------------------------------------------------------------------------
module rbia_reply_checker
    import rbia_pkg::*;
#(
    parameter logic [2:0] CAP_ADDR = 3'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  rbia_req_t   req,
    input  logic        done,
    input  rbia_rsp_t   rsp,
    output int          fill_now,
    output int          owed,
    output int          checked,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ELEM_WIDTH-1:0] cells [DEPTH];
    logic [CAP_W-1:0]      cap_reg;
    int                    head;
    int                    tail;
    int                    cnt;
    int                    n_checked;
    int                    n_err;
    rbia_rsp_t             replies_q [$];

    task automatic ring_apply(input rbia_req_t r, output rbia_rsp_t o);
        int c;
        int pos;
        int len;
        int k;
        c   = (cap_reg == 0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
        pos = int'(r.position);
        len = int'(r.run_length);
        o.status  = ST_OK;
        o.rd_data = '0;
        case (r.req_type)
            REQ_PUSH:
            begin
                if (cnt >= c)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    if (cnt != 0)
                        tail = (tail + 1) % c;
                    cells[tail] = r.wr_data;
                    cnt++;
                end
            end
            REQ_POP:
            begin
                if (cnt == 0)
                begin
                    o.status = ST_EMPTY;
                end
                else
                begin
                    o.rd_data = cells[head];
                    cnt--;
                    if (cnt != 0)
                        head = (head + 1) % c;
                end
            end
            REQ_GET:
            begin
                if (pos >= cnt)
                    o.status = ST_RANGE;
                else
                    o.rd_data = cells[(head + pos) % c];
            end
            REQ_SET:
            begin
                if (pos >= cnt)
                    o.status = ST_RANGE;
                else
                    cells[(head + pos) % c] = r.wr_data;
            end
            REQ_REMOVE:
            begin
                if (pos + len > cnt)
                begin
                    o.status = ST_EMPTY;
                end
                else if (len != 0)
                begin
                    // front or middle run: earlier elements move up by len
                    if (pos + len != cnt)
                    begin
                        for (k = pos; k > 0; k--)
                            cells[(head + k - 1 + len) % c] = cells[(head + k - 1) % c];
                        head = (head + len) % c;
                    end
                    cnt -= len;
                    tail = (cnt == 0) ? head : (head + cnt - 1) % c;
                end
            end
            REQ_CLEAR:
            begin
                head = 0;
                tail = 0;
                cnt  = 0;
            end
            default:
            begin
                o.status = ST_RANGE;
            end
        endcase
        o.fill_level = FILL_W'(cnt);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rbia_rsp_t want;
        rbia_rsp_t pred;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                cells[i] = '0;
            cap_reg   = CAP_RESET;
            head      = 0;
            tail      = 0;
            cnt       = 0;
            n_checked = 0;
            n_err     = 0;
            replies_q.delete();
            fill_now <= 0;
            owed     <= 0;
            checked  <= 0;
            errors   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
            begin
                cap_reg = pwdata[CAP_W-1:0];
                head    = 0;
                tail    = 0;
                cnt     = 0;
            end
            if (done)
            begin
                if (replies_q.size() == 0)
                begin
                    $error("reply beat with none owed: status %0d rd_data %0d fill_level %0d",
                           rsp.status, rsp.rd_data, rsp.fill_level);
                    n_err++;
                end
                else
                begin
                    want = replies_q.pop_front();
                    n_checked++;
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        n_err++;
                    end
                    if (rsp.rd_data !== want.rd_data)
                    begin
                        $error("rd_data: expected %0d, got %0d", want.rd_data, rsp.rd_data);
                        n_err++;
                    end
                    if (rsp.fill_level !== want.fill_level)
                    begin
                        $error("fill_level: expected %0d, got %0d",
                               want.fill_level, rsp.fill_level);
                        n_err++;
                    end
                end
            end
            if (start && !busy)
            begin
                ring_apply(req, pred);
                replies_q.push_back(pred);
            end
            fill_now <= cnt;
            owed     <= replies_q.size();
            checked  <= n_checked;
            errors   <= n_err;
        end
    end

endmodule

FILE: dv/ring_buffer_with_indexed_access_tb.sv
// ----------------------------------------------------------------------------
// ring_buffer_with_indexed_access_tb
// Drives request beats and capacity writes into the indexed ring buffer:
// a directed pass over the corner cases, then random request mixes at
// several capacities with varying sender gaps. The reply checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module ring_buffer_with_indexed_access_tb
    import rbia_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]       CAP_ADDR   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start   = 1'b0;
    logic        busy;
    rbia_req_t   req     = '0;
    logic        done;
    rbia_rsp_t   rsp;

    int fill_now;
    int owed;
    int checked;
    int errors;
    int idle_pct;
    int sent_n;
    int cap_mid;
    int wait_n;

    ring_buffer_with_indexed_access u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp)
    );

    rbia_reply_checker #(.CAP_ADDR(CAP_ADDR)) u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .fill_now (fill_now),
        .owed     (owed),
        .checked  (checked),
        .errors   (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic rbia_req_t beat(logic [REQ_W-1:0] code, int pos, int len, int data);
        rbia_req_t r;
        r.req_type   = code;
        r.position   = POS_W'(pos);
        r.run_length = LEN_W'(len);
        r.wr_data    = DATA_W'(data);
        return r;
    endfunction

    function automatic rbia_req_t pick_request(int fill);
        rbia_req_t r;
        int        w;
        int        lim;
        int        top;
        r.req_type   = REQ_PUSH;
        r.position   = POS_W'($urandom_range(0, 255));
        r.run_length = LEN_W'($urandom_range(0, 256));
        r.wr_data    = DATA_W'($urandom_range(0, 255));
        w = $urandom_range(0, 99);
        if (w < 30)
            r.req_type = REQ_PUSH;
        else if (w < 42)
            r.req_type = REQ_POP;
        else if (w < 60)
            r.req_type = REQ_GET;
        else if (w < 74)
            r.req_type = REQ_SET;
        else if (w < 90)
            r.req_type = REQ_REMOVE;
        else if (w < 92)
            r.req_type = REQ_CLEAR;
        else if (w < 94)
            r.req_type = ($urandom_range(0, 1) != 0) ? REQ_BAD_HI : REQ_BAD_LO;
        else
            r.req_type = REQ_W'($urandom_range(0, 7));
        if (w < 94 && fill > 0 && $urandom_range(0, 99) < 85)
        begin
            if (r.req_type == REQ_GET || r.req_type == REQ_SET)
            begin
                r.position = POS_W'($urandom_range(0, fill - 1));
            end
            else if (r.req_type == REQ_REMOVE)
            begin
                top = (fill > 255) ? 255 : fill;
                r.position = POS_W'($urandom_range(0, top));
                lim = fill - int'(r.position);
                if ($urandom_range(0, 1) != 0 && lim > 3)
                    lim = 3;
                r.run_length = LEN_W'($urandom_range(0, lim));
            end
        end
        return r;
    endfunction

    task automatic send_beat(input rbia_req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        sent_n++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        do
            @(posedge clk);
        while (owed != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input int value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CAP_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_run(input int n);
        repeat (n) send_beat(pick_request(fill_now));
    endtask

    initial
    begin
        sent_n   = 0;
        idle_pct = 32;
        cap_mid  = $urandom_range(2, 255);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // corner cases on the empty queue at reset capacity
        send_beat(beat(REQ_POP, 0, 0, 0));
        send_beat(beat(REQ_GET, 255, 0, 0));
        send_beat(beat(REQ_SET, 255, 0, 255));
        send_beat(beat(REQ_BAD_LO, 0, 0, 0));
        send_beat(beat(REQ_BAD_HI, 255, 256, 255));
        send_beat(beat(REQ_REMOVE, 0, 0, 0));
        send_beat(beat(REQ_REMOVE, 0, 256, 0));

        // small ring: full, wrap, middle, tail and front runs, clear
        write_capacity(4);
        send_beat(beat(REQ_PUSH, 0, 0, 8'h00));
        send_beat(beat(REQ_PUSH, 0, 0, 8'hFF));
        send_beat(beat(REQ_PUSH, 0, 0, 8'hA5));
        send_beat(beat(REQ_PUSH, 0, 0, 8'h5A));
        send_beat(beat(REQ_PUSH, 0, 0, 8'h11));
        send_beat(beat(REQ_GET, 3, 0, 0));
        send_beat(beat(REQ_GET, 4, 0, 0));
        send_beat(beat(REQ_SET, 0, 0, 8'h3C));
        send_beat(beat(REQ_POP, 0, 0, 0));
        send_beat(beat(REQ_PUSH, 0, 0, 8'h77));
        send_beat(beat(REQ_REMOVE, 1, 2, 0));
        send_beat(beat(REQ_GET, 0, 0, 0));
        send_beat(beat(REQ_GET, 1, 0, 0));
        send_beat(beat(REQ_REMOVE, 1, 1, 0));
        send_beat(beat(REQ_REMOVE, 0, 2, 0));
        send_beat(beat(REQ_PUSH, 0, 0, 8'h12));
        send_beat(beat(REQ_PUSH, 0, 0, 8'h34));
        send_beat(beat(REQ_REMOVE, 0, 1, 0));
        send_beat(beat(REQ_REMOVE, 0, 2, 0));
        send_beat(beat(REQ_PUSH, 0, 0, 8'h56));
        send_beat(beat(REQ_CLEAR, 0, 0, 0));

        write_capacity(7);
        random_run(200);
        write_capacity(0);
        random_run(50);

        idle_pct = 52;
        write_capacity(511);
        repeat (258) send_beat(beat(REQ_PUSH, 0, 0, $urandom_range(0, 255)));
        random_run(150);

        idle_pct = 0;
        write_capacity(256);
        random_run(100);
        write_capacity(cap_mid);
        random_run(150);

        start  <= 1'b0;
        wait_n = 0;
        do
        begin
            @(posedge clk);
            wait_n++;
        end
        while ((owed != 0 || busy) && wait_n < 5000);
        if (owed != 0)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            repeat (300) @(posedge clk);
            $display("Sent %0d request beats at capacities 256, 4, 7, 0, 511, 256 and %0d,",
                     sent_n, cap_mid);
            $display("sender gaps at 32, 52 and 0 percent; %0d reply beats compared.", checked);
            if (errors == 0)
                $display("ALL CHECKS PASSED");
            else
                $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

FILE: filelist.f
rtl/rbia_pkg.sv
rtl/rbia_cell.sv
rtl/rbia_rdtree.sv
rtl/ring_buffer_with_indexed_access.sv
dv/rbia_reply_checker.sv
dv/ring_buffer_with_indexed_access_tb.sv
